FILE: hdl/lfkv_pkg.sv
// lfkv_pkg: shared types, constants and helpers of the leg kinematics pipeline
// no dependencies
`default_nettype none
package lfkv_pkg;

	localparam int ANG_W = 34;
	localparam int TRIG_W = 33;
	localparam int MAX_STAGES = 24;
	localparam logic signed [ANG_W-1:0] Q30_PI = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 33'sd652032875;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIP_LEN = 3'd0,
		REG_THIGH_LEN = 3'd1,
		REG_CALF_LEN = 3'd2,
		REG_CALF_OFS = 3'd3,
		REG_HIP_X = 3'd4,
		REG_HIP_Y = 3'd5,
		REG_HIP_Z = 3'd6,
		REG_UNUSED = 3'd7
	} cfg_idx_t;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [23:0] out_t;

	typedef struct packed {
		logic [14:0] hip_len;
		logic [14:0] thigh_len;
		logic [14:0] calf_len;
		logic signed [15:0] calf_ofs;
		logic signed [15:0] hip_x;
		logic signed [15:0] hip_y;
		logic signed [15:0] hip_z;
	} cfg_t;

	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		unique case (i)
			5'd0: r = 34'sd843314857;
			5'd1: r = 34'sd497837830;
			5'd2: r = 34'sd263043837;
			5'd3: r = 34'sd133525159;
			5'd4: r = 34'sd67021687;
			5'd5: r = 34'sd33543516;
			5'd6: r = 34'sd16775851;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194283;
			5'd9: r = 34'sd2097149;
			default: r = (i <= 5'd23) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
		endcase
		return r;
	endfunction

	function automatic out_t sat24(input logic signed [63:0] v);
		out_t r;
		if (v > 64'sd8388607) r = 24'sh7fffff;
		else if (v < -64'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/lfkv_cordic.sv
// lfkv_cordic: pipelined rotation-mode cordic, one stage per iteration
// depends on lfkv_pkg
`default_nettype none
module lfkv_cordic #(
	parameter int STAGES = 16
) (
	input wire logic clk,
	input wire logic signed [16:0] ang,
	output lfkv_pkg::trig_t sin_o,
	output lfkv_pkg::trig_t cos_o
);
	import lfkv_pkg::*;

	localparam int N = (STAGES < MAX_STAGES) ? STAGES : MAX_STAGES;

	logic signed [ANG_W-1:0] z_s [N+1];
	trig_t x_s [N+1];
	trig_t y_s [N+1];
	logic flip_s [N+1];

	logic signed [ANG_W-1:0] z0;

	always_comb begin
		z0 = ANG_W'(ang) <<< 17;
	end

	always_ff @(posedge clk) begin
		flip_s[0] <= (z0 > Q30_HALF_PI) || (z0 < -Q30_HALF_PI);
		if (z0 > Q30_HALF_PI) z_s[0] <= z0 - Q30_PI;
		else if (z0 < -Q30_HALF_PI) z_s[0] <= z0 + Q30_PI;
		else z_s[0] <= z0;
		x_s[0] <= CORDIC_X0;
		y_s[0] <= '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][ANG_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q30(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q30(5'(i));
			end
		end
	end

	assign sin_o = flip_s[N] ? -y_s[N] : y_s[N];
	assign cos_o = flip_s[N] ? -x_s[N] : x_s[N];

endmodule
`default_nettype wire

FILE: hdl/lfkv_kin.sv
// lfkv_kin: pipelined multiply stages from sines and cosines to position and velocity
// depends on lfkv_pkg
`default_nettype none
module lfkv_kin (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic vld_in,
	input wire logic [1:0] leg_in,
	input wire lfkv_pkg::trig_t s1, c1, s2, c2, s3, c3,
	input wire logic signed [16:0] d0, d1, d2,
	input wire lfkv_pkg::cfg_t cfg,
	output logic vld_out,
	output lfkv_pkg::out_t px_o, py_o, pz_o, vx_o, vy_o, vz_o
);
	import lfkv_pkg::*;

	typedef logic signed [63:0] w_t;

	function automatic w_t rnd(input w_t v, input int s);
		return (v + (w_t'(1) <<< (s - 1))) >>> s;
	endfunction

	// stage 1: products of angles
	logic v_s1;
	logic [1:0] leg_s1;
	trig_t s1_s1, c1_s1, s2_s1, c2_s1;
	logic signed [16:0] d0_s1, d1_s1, d2_s1;
	w_t cc_s1, ss_s1, sc_s1, cs_s1;
	// stage 2: c23 s23
	logic v_s2;
	logic [1:0] leg_s2;
	trig_t s1_s2, c1_s2, s2_s2, c2_s2, c23_s2, s23_s2;
	logic signed [16:0] d0_s2, d1_s2, d2_s2;
	// stage 3: link products
	logic v_s3;
	logic [1:0] leg_s3;
	trig_t s1_s3, c1_s3;
	logic signed [16:0] d0_s3, d1_s3, d2_s3;
	w_t a_s3, b_s3, a3_s3, b3_s3;
	// stage 4: products with s1 c1
	logic v_s4;
	logic [1:0] leg_s4;
	logic signed [16:0] d0_s4, d1_s4, d2_s4;
	w_t a_s4, b_s4, a3_s4, hc_s4, sa_s4, hs_s4, ca_s4, sb_s4, sb3_s4, cb_s4, cb3_s4;
	// stage 5: velocity products
	logic v_s5;
	logic [1:0] leg_s5;
	w_t py_s5, pz_s5, px_s5;
	w_t m0_s5, m1_s5, m2_s5, m3_s5, m4_s5, m5_s5, m6_s5, m7_s5;

	w_t h, py_c, pz_c;
	w_t hx, hy, hz;

	always_comb begin
		h = leg_s3[0] ? -((w_t'(cfg.hip_len) + w_t'(cfg.calf_ofs)) <<< 15)
			: ((w_t'(cfg.hip_len) + w_t'(cfg.calf_ofs)) <<< 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vld_out <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		leg_s1 <= leg_in;
		s1_s1 <= s1; c1_s1 <= c1; s2_s1 <= s2; c2_s1 <= c2;
		d0_s1 <= d0; d1_s1 <= d1; d2_s1 <= d2;
		cc_s1 <= w_t'(c2) * w_t'(c3);
		ss_s1 <= w_t'(s2) * w_t'(s3);
		sc_s1 <= w_t'(s2) * w_t'(c3);
		cs_s1 <= w_t'(c2) * w_t'(s3);

		leg_s2 <= leg_s1;
		s1_s2 <= s1_s1; c1_s2 <= c1_s1; s2_s2 <= s2_s1; c2_s2 <= c2_s1;
		d0_s2 <= d0_s1; d1_s2 <= d1_s1; d2_s2 <= d2_s1;
		c23_s2 <= TRIG_W'(rnd(cc_s1 - ss_s1, 30));
		s23_s2 <= TRIG_W'(rnd(sc_s1 + cs_s1, 30));

		leg_s3 <= leg_s2;
		s1_s3 <= s1_s2; c1_s3 <= c1_s2;
		d0_s3 <= d0_s2; d1_s3 <= d1_s2; d2_s3 <= d2_s2;
		a_s3 <= rnd(w_t'(cfg.calf_len) * w_t'(c23_s2) + w_t'(cfg.thigh_len) * w_t'(c2_s2), 15);
		b_s3 <= rnd(w_t'(cfg.calf_len) * w_t'(s23_s2) + w_t'(cfg.thigh_len) * w_t'(s2_s2), 15);
		a3_s3 <= rnd(w_t'(cfg.calf_len) * w_t'(c23_s2), 15);
		b3_s3 <= rnd(w_t'(cfg.calf_len) * w_t'(s23_s2), 15);

		leg_s4 <= leg_s3;
		d0_s4 <= d0_s3; d1_s4 <= d1_s3; d2_s4 <= d2_s3;
		a_s4 <= a_s3; b_s4 <= b_s3; a3_s4 <= a3_s3;
		hc_s4 <= rnd(h * w_t'(c1_s3), 30);
		sa_s4 <= rnd(w_t'(s1_s3) * a_s3, 30);
		hs_s4 <= rnd(h * w_t'(s1_s3), 30);
		ca_s4 <= rnd(w_t'(c1_s3) * a_s3, 30);
		sb_s4 <= rnd(w_t'(s1_s3) * b_s3, 30);
		sb3_s4 <= rnd(w_t'(s1_s3) * b3_s3, 30);
		cb_s4 <= rnd(w_t'(c1_s3) * b_s3, 30);
		cb3_s4 <= rnd(w_t'(c1_s3) * b3_s3, 30);

		leg_s5 <= leg_s4;
		px_s5 <= b_s4;
		py_s5 <= py_c;
		pz_s5 <= pz_c;
		m0_s5 <= a_s4 * w_t'(d1_s4);
		m1_s5 <= a3_s4 * w_t'(d2_s4);
		m2_s5 <= -pz_c * w_t'(d0_s4);
		m3_s5 <= -sb_s4 * w_t'(d1_s4);
		m4_s5 <= -sb3_s4 * w_t'(d2_s4);
		m5_s5 <= py_c * w_t'(d0_s4);
		m6_s5 <= cb_s4 * w_t'(d1_s4);
		m7_s5 <= cb3_s4 * w_t'(d2_s4);

		px_o <= sat24(rnd(px_s5, 10) + hx);
		py_o <= sat24(rnd(py_s5, 10) + hy);
		pz_o <= sat24(rnd(pz_s5, 10) + hz);
		vx_o <= sat24(rnd(m0_s5 + m1_s5, 25));
		vy_o <= sat24(rnd(m2_s5 + m3_s5 + m4_s5, 25));
		vz_o <= sat24(rnd(m5_s5 + m6_s5 + m7_s5, 25));
	end

	always_comb begin
		py_c = hc_s4 + sa_s4;
		pz_c = hs_s4 - ca_s4;
		hx = (leg_s5[1] == 1'b0) ? -(w_t'(cfg.hip_x) <<< 5) : (w_t'(cfg.hip_x) <<< 5);
		hy = leg_s5[0] ? -(w_t'(cfg.hip_y) <<< 5) : (w_t'(cfg.hip_y) <<< 5);
		hz = w_t'(cfg.hip_z) <<< 5;
	end

	assert property (@(posedge clk) disable iff (!arst_n) vld_in |-> ##6 vld_out)
		else $error("valid lost in kinematics pipe");
	assert property (@(posedge clk) disable iff (!arst_n) !v_s5 |=> !vld_out)
		else $error("spurious output valid");
	assert property (@(posedge clk) disable iff (!arst_n) v_s3 |=> v_s4)
		else $error("valid dropped between stages");

endmodule
`default_nettype wire

FILE: hdl/leg_forward_kinematics_velocity_top.sv
// leg_forward_kinematics_velocity_top: foot position and velocity of one leg
// depends on lfkv_pkg, lfkv_cordic, lfkv_kin
//
// channel  | signals                                  | direction
// cmd      | start, busy, leg, angles, rates          | in
// result   | done, foot_pos_*, foot_vel_*             | out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// one item per cycle; each item passes the cordic pipeline and then the kinematics pipeline
// busy is always low; done strobes for one cycle with each result
// asynchronous reset clears valid bits and configuration registers
`default_nettype none
module leg_forward_kinematics_velocity_top #(
	parameter int CORDIC_STAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] leg,
	input wire logic signed [15:0] hip_angle,
	input wire logic signed [15:0] thigh_angle,
	input wire logic signed [15:0] calf_angle,
	input wire logic signed [15:0] hip_rate,
	input wire logic signed [15:0] thigh_rate,
	input wire logic signed [15:0] calf_rate,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [lfkv_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output logic done,
	output logic signed [23:0] foot_pos_x,
	output logic signed [23:0] foot_pos_y,
	output logic signed [23:0] foot_pos_z,
	output logic signed [23:0] foot_vel_x,
	output logic signed [23:0] foot_vel_y,
	output logic signed [23:0] foot_vel_z
);
	import lfkv_pkg::*;

	localparam int N = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
	localparam int DLY = N + 1;

	cfg_t cfg_q;
	logic [DLY-1:0] vld_q;
	logic [1:0] leg_q [DLY];
	logic signed [16:0] d0_q [DLY];
	logic signed [16:0] d1_q [DLY];
	logic signed [16:0] d2_q [DLY];
	trig_t s1, c1, s2, c2, s3, c3;
	logic accept;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_HIP_LEN: cfg_q.hip_len <= cfg_data[14:0];
				REG_THIGH_LEN: cfg_q.thigh_len <= cfg_data[14:0];
				REG_CALF_LEN: cfg_q.calf_len <= cfg_data[14:0];
				REG_CALF_OFS: cfg_q.calf_ofs <= cfg_data;
				REG_HIP_X: cfg_q.hip_x <= cfg_data;
				REG_HIP_Y: cfg_q.hip_y <= cfg_data;
				REG_HIP_Z: cfg_q.hip_z <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[DLY-2:0], accept};
	end

	always_ff @(posedge clk) begin
		leg_q[0] <= leg;
		d0_q[0] <= 17'(hip_rate);
		d1_q[0] <= -17'(thigh_rate);
		d2_q[0] <= -17'(calf_rate);
		for (int i = 1; i < DLY; i++) begin
			leg_q[i] <= leg_q[i-1];
			d0_q[i] <= d0_q[i-1];
			d1_q[i] <= d1_q[i-1];
			d2_q[i] <= d2_q[i-1];
		end
	end

	lfkv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hip (
		.clk, .ang(17'(hip_angle)), .sin_o(s1), .cos_o(c1));
	lfkv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_thigh (
		.clk, .ang(-17'(thigh_angle)), .sin_o(s2), .cos_o(c2));
	lfkv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_calf (
		.clk, .ang(-17'(calf_angle)), .sin_o(s3), .cos_o(c3));

	lfkv_kin u_kin (
		.clk, .arst_n,
		.vld_in(vld_q[DLY-1]), .leg_in(leg_q[DLY-1]),
		.s1, .c1, .s2, .c2, .s3, .c3,
		.d0(d0_q[DLY-1]), .d1(d1_q[DLY-1]), .d2(d2_q[DLY-1]),
		.cfg(cfg_q),
		.vld_out(done),
		.px_o(foot_pos_x), .py_o(foot_pos_y), .pz_o(foot_pos_z),
		.vx_o(foot_vel_x), .vy_o(foot_vel_y), .vz_o(foot_vel_z)
	);

endmodule
`default_nettype wire
